// File: rtl/ipv4hp_pkg.sv
// shared types and constants for the ipv4 header parser
package ipv4hp_pkg;

  localparam int unsigned CountW       = 6;
  localparam logic [CountW-1:0] CountMax = 6'd63;
  localparam logic [CountW-1:0] MinHdrBytes = 6'd20;
  localparam logic [3:0] Ipv4Version  = 4'd4;
  localparam logic [3:0] MinIhl       = 4'd5;
  localparam logic [15:0] SumGood     = 16'hFFFF;
  localparam int unsigned OutDataW    = 144;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_BAD_VERSION  = 3'd2,
    ST_BAD_IHL      = 3'd3,
    ST_BAD_CHECKSUM = 3'd4
  } status_t;

  // per-packet parse state, also used for the view that includes the current word
  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic [7:0]        first_byte;
    logic [7:0]        service_byte;
    logic [15:0]       length_reg;
    logic [15:0]       ident_reg;
    logic [15:0]       flagfrag_reg;
    logic [7:0]        ttl_reg;
    logic [7:0]        proto_reg;
    logic [31:0]       src_reg;
    logic [31:0]       dst_reg;
    logic [15:0]       sum_acc;
    logic [7:0]        pending_high;
  } hdr_state_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  header_words;
    logic [5:0]  dscp;
    logic [1:0]  ecn;
    logic [15:0] datagram_len;
    logic [15:0] identification;
    logic [2:0]  frag_flags;
    logic [12:0] fragment_offset;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } result_t;

  // ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// File: rtl/ipv4hp_capture.sv
// byte counter, header field capture and running header checksum
module ipv4hp_capture (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [7:0]             packet_byte,
  input  logic                   last_byte,
  output ipv4hp_pkg::hdr_state_t view
);

  ipv4hp_pkg::hdr_state_t st;
  ipv4hp_pkg::hdr_state_t st_next;
  logic [ipv4hp_pkg::CountW-1:0] idx;
  logic [ipv4hp_pkg::CountW-1:0] hdr_bytes;

  assign idx = st.byte_count;

  always_comb begin
    st_next = st;
    if (idx == '0) begin
      st_next.first_byte = packet_byte;
    end
    hdr_bytes = {st_next.first_byte[3:0], 2'b00};
    if (idx != ipv4hp_pkg::CountMax) begin
      case (idx) inside
        6'd1:          st_next.service_byte = packet_byte;
        [6'd2:6'd3]:   st_next.length_reg   = {st.length_reg[7:0], packet_byte};
        [6'd4:6'd5]:   st_next.ident_reg    = {st.ident_reg[7:0], packet_byte};
        [6'd6:6'd7]:   st_next.flagfrag_reg = {st.flagfrag_reg[7:0], packet_byte};
        6'd8:          st_next.ttl_reg      = packet_byte;
        6'd9:          st_next.proto_reg    = packet_byte;
        [6'd12:6'd15]: st_next.src_reg      = {st.src_reg[23:0], packet_byte};
        [6'd16:6'd19]: st_next.dst_reg      = {st.dst_reg[23:0], packet_byte};
        default: ;
      endcase
      // only words inside the ihl-sized header feed the checksum
      if (idx < hdr_bytes) begin
        if (!idx[0]) begin
          st_next.pending_high = packet_byte;
        end else begin
          st_next.sum_acc = ipv4hp_pkg::oc_add(st.sum_acc, {st.pending_high, packet_byte});
        end
      end
      st_next.byte_count = idx + 6'd1;
    end
  end

  assign view = st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      if (last_byte) begin
        st <= '0;
      end else begin
        st <= st_next;
      end
    end
  end

endmodule

// File: rtl/ipv4hp_status.sv
// status checks and result field decode for the final word of a packet
module ipv4hp_status (
  input  ipv4hp_pkg::hdr_state_t view,
  output ipv4hp_pkg::result_t    result
);

  logic [3:0]                    ihl;
  logic [3:0]                    version;
  logic [ipv4hp_pkg::CountW-1:0] hdr_bytes;
  ipv4hp_pkg::status_t           status;

  assign ihl       = view.first_byte[3:0];
  assign version   = view.first_byte[7:4];
  assign hdr_bytes = {ihl, 2'b00};

  // saturated count of 63 compares the same as the true length against 20 and ihl*4
  always_comb begin
    if (view.byte_count < ipv4hp_pkg::MinHdrBytes) begin
      status = ipv4hp_pkg::ST_SHORT;
    end else if (version != ipv4hp_pkg::Ipv4Version) begin
      status = ipv4hp_pkg::ST_BAD_VERSION;
    end else if (ihl < ipv4hp_pkg::MinIhl) begin
      status = ipv4hp_pkg::ST_BAD_IHL;
    end else if (view.byte_count < hdr_bytes) begin
      status = ipv4hp_pkg::ST_SHORT;
    end else if (view.sum_acc != ipv4hp_pkg::SumGood) begin
      status = ipv4hp_pkg::ST_BAD_CHECKSUM;
    end else begin
      status = ipv4hp_pkg::ST_OK;
    end
  end

  always_comb begin
    result        = '0;
    result.status = status;
    if (status == ipv4hp_pkg::ST_OK || status == ipv4hp_pkg::ST_BAD_CHECKSUM) begin
      result.header_words    = ihl;
      result.dscp            = view.service_byte[7:2];
      result.ecn             = view.service_byte[1:0];
      result.datagram_len    = view.length_reg;
      result.identification  = view.ident_reg;
      result.frag_flags      = view.flagfrag_reg[15:13];
      result.fragment_offset = view.flagfrag_reg[12:0];
      result.time_to_live    = view.ttl_reg;
      result.protocol_number = view.proto_reg;
      result.source_address  = view.src_reg;
      result.dest_address    = view.dst_reg;
    end
  end

endmodule

// File: rtl/ipv4_header_parser.sv
// IPv4 header parser: one packet byte per word in, one result word per packet out.
// Every input word is registered, then it updates the byte count,
// the captured header fields and the ones-complement checksum; the word marked tlast
// also produces the result, which is held in an output register until taken. A new
// byte is accepted every cycle unless the input stalls, and the result of a packet
// passes through the input register and then the output register. Only a final byte waiting on a
// full output register that is not being read stalls the input.
module ipv4_header_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] packet_byte
  input  logic                            s_tlast,  // last_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] header_words, [9:4] dscp, [11:10] ecn, [27:12] datagram_len,
  // [43:28] identification, [46:44] frag_flags, [59:47] fragment_offset,
  // [67:60] time_to_live, [75:68] protocol_number, [107:76] source_address,
  // [139:108] dest_address, [143:140] zero
  output logic [ipv4hp_pkg::OutDataW-1:0] m_tdata,
  output logic [2:0]                      m_tuser   // [2:0] status
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_last;
  logic                   advance;
  ipv4hp_pkg::hdr_state_t view;
  ipv4hp_pkg::result_t    result;
  ipv4hp_pkg::result_t    out_reg;

  // non-final bytes never need the output register
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ipv4hp_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .packet_byte (in_byte),
    .last_byte   (in_last),
    .view        (view)
  );

  ipv4hp_status u_status (
    .view   (view),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_reg <= result;
    end
  end

  assign m_tuser = out_reg.status;
  assign m_tdata = {4'd0,
                    out_reg.dest_address,
                    out_reg.source_address,
                    out_reg.protocol_number,
                    out_reg.time_to_live,
                    out_reg.fragment_offset,
                    out_reg.frag_flags,
                    out_reg.identification,
                    out_reg.datagram_len,
                    out_reg.ecn,
                    out_reg.dscp,
                    out_reg.header_words};

endmodule

// File: rtl/ipv4hp_checker.sv
// port-level assertions for the ipv4 header parser, bound to the top level
module ipv4hp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ipv4hp_pkg::OutDataW-1:0] m_tdata,
  input logic [2:0]                      m_tuser
);

  logic fields_valid;

  assign fields_valid = (m_tuser == ipv4hp_pkg::ST_OK) ||
                        (m_tuser == ipv4hp_pkg::ST_BAD_CHECKSUM);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !fields_valid |-> m_tdata == '0)
    else $error("decoded fields not zero on a header error");

  a_ihl_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && fields_valid |-> m_tdata[3:0] >= ipv4hp_pkg::MinIhl)
    else $error("decoded header reported with ihl below five");

endmodule

bind ipv4_header_parser ipv4hp_checker u_ipv4hp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: bench/ipv4_header_parser_tb.sv
// testbench for the ipv4 header parser: packet streams checked against a predictor
`timescale 1ns / 100ps

module ipv4_header_parser_tb;

  localparam int HoldCycles = 300;
  localparam int QuietLimit = 2000;

  typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;
  logic                            s_tlast;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ipv4hp_pkg::OutDataW-1:0] m_tdata;
  logic [2:0]                      m_tuser;

  // predictor state for the packet in flight
  logic [7:0]  rx_hdr [20];
  int unsigned rx_count = 0;
  logic [31:0] rx_sum = '0;
  logic [7:0]  rx_hi = '0;

  ipv4hp_pkg::result_t exp_q [$];
  logic [7:0]  pkt [$];
  int          bytes_sent = 0;
  int          mismatches = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  bit          hold_arm = 1'b0;
  int          hold_left = 0;
  int          quiet = 0;

  ipv4_header_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // end-around carry folding of a wide sum
  function automatic logic [15:0] fold16(input logic [31:0] s);
    while (s > 32'hFFFF) s = s[15:0] + s[31:16];
    return s[15:0];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    int unsigned         idx;
    int unsigned         hdr_len;
    ipv4hp_pkg::result_t want;
    idx = rx_count;
    if (idx < 20) rx_hdr[idx] = b;
    hdr_len = 4 * rx_hdr[0][3:0];
    if (idx < hdr_len) begin
      if (idx[0] == 1'b0) rx_hi = b;
      else rx_sum += {rx_hi, b};
    end
    rx_count++;
    if (!last) return;
    want = '0;
    if (idx + 1 < ipv4hp_pkg::MinHdrBytes) want.status = ipv4hp_pkg::ST_SHORT;
    else if (rx_hdr[0][7:4] != ipv4hp_pkg::Ipv4Version) want.status = ipv4hp_pkg::ST_BAD_VERSION;
    else if (rx_hdr[0][3:0] < ipv4hp_pkg::MinIhl) want.status = ipv4hp_pkg::ST_BAD_IHL;
    else if (idx + 1 < hdr_len) want.status = ipv4hp_pkg::ST_SHORT;
    else if (fold16(rx_sum) != ipv4hp_pkg::SumGood) want.status = ipv4hp_pkg::ST_BAD_CHECKSUM;
    else want.status = ipv4hp_pkg::ST_OK;
    if (want.status == ipv4hp_pkg::ST_OK || want.status == ipv4hp_pkg::ST_BAD_CHECKSUM) begin
      want.header_words    = rx_hdr[0][3:0];
      want.dscp            = rx_hdr[1][7:2];
      want.ecn             = rx_hdr[1][1:0];
      want.datagram_len    = {rx_hdr[2], rx_hdr[3]};
      want.identification  = {rx_hdr[4], rx_hdr[5]};
      want.frag_flags      = rx_hdr[6][7:5];
      want.fragment_offset = {rx_hdr[6][4:0], rx_hdr[7]};
      want.time_to_live    = rx_hdr[8];
      want.protocol_number = rx_hdr[9];
      want.source_address  = {rx_hdr[12], rx_hdr[13], rx_hdr[14], rx_hdr[15]};
      want.dest_address    = {rx_hdr[16], rx_hdr[17], rx_hdr[18], rx_hdr[19]};
    end
    exp_q.push_back(want);
    rx_count = 0;
    rx_sum   = '0;
    rx_hi    = '0;
  endfunction

  // header with a correct checksum over the first ihl*4 bytes, at least 20 bytes long
  function automatic void build_header(input logic [3:0] ver, input logic [3:0] ihl,
                                       input fill_t fill);
    int          n;
    logic [31:0] acc;
    n = (ihl > 5) ? 4 * ihl : 20;
    pkt.delete();
    for (int i = 0; i < n; i++)
      pkt.push_back(fill == FILL_ZERO ? 8'h00 : fill == FILL_ONES ? 8'hFF : 8'($urandom));
    pkt[0]  = {ver, ihl};
    pkt[10] = 8'h00;
    pkt[11] = 8'h00;
    acc = '0;
    for (int i = 0; i + 1 < 4 * ihl; i += 2) acc += {pkt[i], pkt[i + 1]};
    {pkt[10], pkt[11]} = ~fold16(acc);
  endfunction

  function automatic string diff_fields(input ipv4hp_pkg::result_t e,
                                        input ipv4hp_pkg::result_t g);
    string s;
    s = "";
    if (e.status !== g.status) s = {s, " status"};
    if (e.header_words !== g.header_words) s = {s, " header_words"};
    if (e.dscp !== g.dscp) s = {s, " dscp"};
    if (e.ecn !== g.ecn) s = {s, " ecn"};
    if (e.datagram_len !== g.datagram_len) s = {s, " datagram_len"};
    if (e.identification !== g.identification) s = {s, " identification"};
    if (e.frag_flags !== g.frag_flags) s = {s, " frag_flags"};
    if (e.fragment_offset !== g.fragment_offset) s = {s, " fragment_offset"};
    if (e.time_to_live !== g.time_to_live) s = {s, " time_to_live"};
    if (e.protocol_number !== g.protocol_number) s = {s, " protocol_number"};
    if (e.source_address !== g.source_address) s = {s, " source_address"};
    if (e.dest_address !== g.dest_address) s = {s, " dest_address"};
    return s;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // result checker
  always @(posedge clk) begin
    ipv4hp_pkg::result_t got;
    ipv4hp_pkg::result_t want;
    string               odd;
    if (!rst && m_tvalid && m_tready) begin
      got.status          = ipv4hp_pkg::status_t'(m_tuser);
      got.header_words    = m_tdata[3:0];
      got.dscp            = m_tdata[9:4];
      got.ecn             = m_tdata[11:10];
      got.datagram_len    = m_tdata[27:12];
      got.identification  = m_tdata[43:28];
      got.frag_flags      = m_tdata[46:44];
      got.fragment_offset = m_tdata[59:47];
      got.time_to_live    = m_tdata[67:60];
      got.protocol_number = m_tdata[75:68];
      got.source_address  = m_tdata[107:76];
      got.dest_address    = m_tdata[139:108];
      if (exp_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d data %h", m_tuser, m_tdata));
      end else begin
        want = exp_q.pop_front();
        odd = diff_fields(want, got);
        if (m_tdata[ipv4hp_pkg::OutDataW-1:140] !== 4'd0) odd = {odd, " pad"};
        if (odd != "")
          note_mismatch($sformatf("mismatch in%s: expected %h got %h", odd, want, got));
      end
    end
  end

  // receiver side, with an optional long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_arm) begin
      hold_left = HoldCycles;
      hold_arm  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    absorb_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sends len bytes of pkt, random bytes past its end
  task automatic send_pkt(input int len);
    for (int i = 0; i < len; i++)
      send_byte(i < pkt.size() ? pkt[i] : 8'($urandom), i == len - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_packet();
    int kind;
    int ihl;
    int len;
    int pos;
    kind = $urandom_range(99);
    ihl  = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
    build_header(ipv4hp_pkg::Ipv4Version, 4'(ihl), FILL_RAND);
    len = pkt.size() + (($urandom_range(9) == 0) ? $urandom_range(50) : $urandom_range(8));
    if (kind < 70) begin
      // well formed, random content
    end else if (kind < 78) begin
      pos = $urandom_range(pkt.size() - 1);
      pkt[pos] = pkt[pos] ^ 8'(1 << $urandom_range(7));
    end else if (kind < 84) begin
      pkt[0][7:4] = 4'($urandom_range(15));
    end else if (kind < 88) begin
      pkt[0][3:0] = 4'($urandom_range(4));
    end else if (kind < 94) begin
      len = $urandom_range(pkt.size() - 1, 1);
    end else begin
      pkt.delete();
      len = $urandom_range(40, 1);
    end
    send_pkt(len);
  endtask

  task automatic test_good_headers();
    build_header(ipv4hp_pkg::Ipv4Version, ipv4hp_pkg::MinIhl, FILL_ONES);
    send_pkt(20);
    build_header(ipv4hp_pkg::Ipv4Version, ipv4hp_pkg::MinIhl, FILL_ZERO);
    send_pkt(20);
    build_header(ipv4hp_pkg::Ipv4Version, 4'd6, FILL_RAND);
    send_pkt(24);
    build_header(ipv4hp_pkg::Ipv4Version, 4'd15, FILL_RAND);
    send_pkt(60);
    wait_drained();
  endtask

  task automatic test_long_packets();
    // payload runs past the point where the byte count saturates
    build_header(ipv4hp_pkg::Ipv4Version, ipv4hp_pkg::MinIhl, FILL_RAND);
    send_pkt(100);
    build_header(ipv4hp_pkg::Ipv4Version, 4'd15, FILL_ONES);
    send_pkt(80);
    wait_drained();
  endtask

  task automatic test_short_packets();
    build_header(ipv4hp_pkg::Ipv4Version, ipv4hp_pkg::MinIhl, FILL_RAND);
    send_pkt(1);
    send_pkt(19);
    build_header(4'd6, ipv4hp_pkg::MinIhl, FILL_RAND);
    send_pkt(10);
    build_header(ipv4hp_pkg::Ipv4Version, 4'd15, FILL_RAND);
    send_pkt(40);
    build_header(ipv4hp_pkg::Ipv4Version, 4'd6, FILL_RAND);
    send_pkt(23);
    wait_drained();
  endtask

  task automatic test_bad_version_ihl();
    build_header(4'd0, ipv4hp_pkg::MinIhl, FILL_RAND);
    send_pkt(20);
    build_header(4'd15, ipv4hp_pkg::MinIhl, FILL_ONES);
    send_pkt(20);
    build_header(4'd6, 4'd0, FILL_RAND);
    send_pkt(20);
    build_header(ipv4hp_pkg::Ipv4Version, 4'd4, FILL_RAND);
    send_pkt(20);
    build_header(ipv4hp_pkg::Ipv4Version, 4'd0, FILL_ZERO);
    send_pkt(20);
    wait_drained();
  endtask

  task automatic test_bad_checksum();
    build_header(ipv4hp_pkg::Ipv4Version, ipv4hp_pkg::MinIhl, FILL_RAND);
    pkt[11] = pkt[11] ^ 8'h01;
    send_pkt(20);
    // corrupted option byte is still covered by the sum
    build_header(ipv4hp_pkg::Ipv4Version, 4'd15, FILL_RAND);
    pkt[59] = pkt[59] ^ 8'h80;
    send_pkt(64);
    wait_drained();
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct, input int budget);
    int stop_at;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) random_packet();
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    @(posedge clk);
    hold_arm = 1'b1;
    @(negedge clk);
    repeat (5) begin
      build_header(ipv4hp_pkg::Ipv4Version, ipv4hp_pkg::MinIhl, FILL_RAND);
      send_pkt(pkt.size() + $urandom_range(4));
    end
    wait_drained();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_good_headers();
    test_long_packets();
    test_short_packets();
    test_bad_version_ihl();
    test_bad_checksum();
    test_random(0, 0, 80);
    test_random(73, 0, 80);
    test_random(0, 73, 80);
    test_random(12, 12, 80);
    test_backpressure();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
